### sv/dmei_pkg.sv
package dmei_pkg;

    localparam int HRES         = 60;
    localparam int VRES         = 3 * 72;
    localparam int DIV_W        = 18;

    localparam logic [2:0]  PITCH_PICA   = 3'(HRES / 10);
    localparam logic [2:0]  PITCH_ELITE  = 3'(HRES / 12);
    localparam logic [10:0] TAB_DEFAULT  = 11'(HRES * 8 / 10);
    localparam logic [9:0]  LINE_SIX     = 10'(VRES / 6);
    localparam logic [9:0]  LINE_EIGHT   = 10'(VRES / 8);
    localparam logic [9:0]  LINE_SEVEN   = 10'(VRES * 7 / 72);
    localparam logic [17:0] FORM_DEFAULT = 18'(VRES * 11);
    localparam logic [17:0] DOWN_MAX     = 18'h3FFFF;
    localparam logic [7:0]  VRES_B       = 8'(VRES);

    localparam logic [6:0]  INV_FONT     = 7'h40;
    localparam logic [18:0] INV_DOWN     = 19'h40000;
    localparam logic [16:0] INV_ACROSS   = 17'h10000;

    // event kinds
    localparam logic [2:0] K_PAGE_BEGIN = 3'd0;
    localparam logic [2:0] K_PAGE_END   = 3'd1;
    localparam logic [2:0] K_MOVE       = 3'd2;
    localparam logic [2:0] K_FONT       = 3'd3;
    localparam logic [2:0] K_GLYPH      = 3'd4;
    localparam logic [2:0] K_UNDERLINE  = 3'd5;
    localparam logic [2:0] K_GFX_START  = 3'd6;
    localparam logic [2:0] K_GFX_DATA   = 3'd7;

    // font bits
    localparam logic [5:0] F_BOLD   = 6'h01;
    localparam logic [5:0] F_ITALIC = 6'h02;
    localparam logic [5:0] F_ELITE  = 6'h04;
    localparam logic [5:0] F_UNDER  = 6'h08;
    localparam logic [5:0] F_SCRIPT = 6'h10;
    localparam logic [5:0] F_SUPER  = 6'h20;

    // control codes
    localparam logic [7:0] C_BS    = 8'h08;
    localparam logic [7:0] C_HT    = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_ESC   = 8'h1B;
    localparam logic [7:0] C_SPACE = 8'h20;

    // escape command letters
    localparam logic [7:0] CMD_GFX    = 8'h2A;
    localparam logic [7:0] CMD_GK     = 8'h4B;
    localparam logic [7:0] CMD_GL     = 8'h4C;
    localparam logic [7:0] CMD_GY     = 8'h59;
    localparam logic [7:0] CMD_GZ     = 8'h5A;
    localparam logic [7:0] CMD_UNDER  = 8'h2D;
    localparam logic [7:0] CMD_LSP    = 8'h33;
    localparam logic [7:0] CMD_LSP3   = 8'h41;
    localparam logic [7:0] CMD_FEED   = 8'h4A;
    localparam logic [7:0] CMD_SKIPN  = 8'h4E;
    localparam logic [7:0] CMD_SKIPQ  = 8'h51;
    localparam logic [7:0] CMD_SKIPR  = 8'h52;
    localparam logic [7:0] CMD_SCRIPT = 8'h53;
    localparam logic [7:0] CMD_LMARG  = 8'h6C;
    localparam logic [7:0] CMD_FORM   = 8'h43;
    localparam logic [7:0] CMD_TABSET = 8'h65;
    localparam logic [7:0] CMD_SKIP   = 8'h66;
    localparam logic [7:0] CMD_LS8    = 8'h30;
    localparam logic [7:0] CMD_LS7    = 8'h31;
    localparam logic [7:0] CMD_LS6    = 8'h32;
    localparam logic [7:0] CMD_ITON   = 8'h34;
    localparam logic [7:0] CMD_ITOFF  = 8'h35;
    localparam logic [7:0] CMD_BOLDE  = 8'h45;
    localparam logic [7:0] CMD_BOLDG  = 8'h47;
    localparam logic [7:0] CMD_BOLDF  = 8'h46;
    localparam logic [7:0] CMD_BOLDH  = 8'h48;
    localparam logic [7:0] CMD_ELITE  = 8'h4D;
    localparam logic [7:0] CMD_PICA   = 8'h50;
    localparam logic [7:0] CMD_NOSCR  = 8'h54;
    localparam logic [7:0] CMD_INIT   = 8'h40;

    typedef struct packed {
        logic [2:0]         kind;
        logic [17:0]        vert;
        logic signed [15:0] horiz;
        logic [15:0]        value;
        logic signed [15:0] uend;
        logic [15:0]        count;
    } ev_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fin;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic ev_left;
        logic out_free;
    } sts_t;

    function automatic ev_t mk_ev(input logic [2:0] kind, input logic [17:0] vert,
                                  input logic signed [15:0] horiz, input logic [15:0] value,
                                  input logic signed [15:0] uend, input logic [15:0] count);
        ev_t e;
        e.kind  = kind;
        e.vert  = vert;
        e.horiz = horiz;
        e.value = value;
        e.uend  = uend;
        e.count = count;
        return e;
    endfunction

    function automatic logic signed [15:0] sat_h(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) r = 16'sh7FFF;
        else if (v < -17'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic [17:0] sat_v(input logic [19:0] v);
        logic [17:0] r;
        if (v > 20'(DOWN_MAX)) r = DOWN_MAX;
        else r = v[17:0];
        return r;
    endfunction

endpackage

### sv/dmei_div.sv
module dmei_div #(
    parameter int W = dmei_pkg::DIV_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]   rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic [W:0]   shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // one restoring step per cycle
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = shifted - {1'b0, dvs_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[W-1:0];

endmodule

### sv/dmei_ctrl.sv
module dmei_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  dmei_pkg::sts_t sts,
    output dmei_pkg::cmd_t cmd
);
    import dmei_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DIV;
            ST_DIV: begin
                if (!sts.need_div) state_next = ST_EMIT;
                else if (sts.div_done) state_next = ST_FIN;
            end
            ST_FIN:  state_next = ST_EMIT;
            ST_EMIT: if (!sts.ev_left) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd.load = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec = (state_reg == ST_EXEC);
    assign cmd.fin  = (state_reg == ST_FIN);
    assign cmd.pop  = (state_reg == ST_EMIT) && sts.ev_left && sts.out_free;

endmodule

### sv/dmei_dp.sv
module dmei_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    s_byte,
    input  logic          s_eof,
    input  dmei_pkg::cmd_t cmd,
    output dmei_pkg::sts_t sts,
    output logic          m_tvalid,
    input  logic          m_tready,
    output dmei_pkg::ev_t m_ev,
    output logic          m_last
);
    import dmei_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_ESC, PH_ARG1, PH_ARG2, PH_GMODE, PH_GLO, PH_GHI, PH_GDATA
    } phase_t;

    typedef enum logic [1:0] { P_NONE, P_PAGE, P_TAB, P_VTAB } pend_t;

    typedef struct packed {
        phase_t             phase;
        logic [7:0]         cmd;
        logic [7:0]         farg;
        logic [15:0]        brem;
        logic [5:0]         font;
        logic signed [15:0] across;
        logic [17:0]        down;
        logic [2:0]         pitch;
        logic [10:0]        tab;
        logic [10:0]        lm;
        logic [9:0]         lp;
        logic [17:0]        tabd;
        logic [17:0]        fl;
        logic               open;
        logic [6:0]         sfont;
        logic [18:0]        sdown;
        logic [16:0]        sacross;
        logic               run;
        logic signed [15:0] rstart;
        logic [15:0]        pcount;
    } st_t;

    function automatic st_t st_clear(input logic [15:0] pc);
        st_t s;
        s.phase   = PH_IDLE;
        s.cmd     = '0;
        s.farg    = '0;
        s.brem    = '0;
        s.font    = '0;
        s.across  = '0;
        s.down    = '0;
        s.pitch   = PITCH_PICA;
        s.tab     = TAB_DEFAULT;
        s.lm      = '0;
        s.lp      = LINE_SIX;
        s.tabd    = '0;
        s.fl      = FORM_DEFAULT;
        s.open    = 1'b0;
        s.sfont   = INV_FONT;
        s.sdown   = INV_DOWN;
        s.sacross = INV_ACROSS;
        s.run     = 1'b0;
        s.rstart  = '0;
        s.pcount  = pc;
        return s;
    endfunction

    st_t   st_reg, st_x, st_f;
    ev_t   ev_reg [4];
    ev_t   ev_x   [4];
    logic [2:0] evn_reg, evi_reg, n_x;
    pend_t pend_reg, pend_x;
    logic [7:0] byte_reg;
    logic       eof_reg;
    logic [DIV_W-1:0] dvd_x, dvs_x, quo, rem;
    logic       div_done;
    ev_t        out_reg;
    logic       out_last_reg, out_valid_reg;

    logic [6:0]  lo;
    logic        printable;
    logic [10:0] ctimes;
    logic [17:0] ltimes;
    logic [28:0] tab_sum;
    logic [36:0] vprod;

    assign lo        = byte_reg[6:0];
    assign printable = (lo >= 7'h20) && (lo != 7'h7F);
    assign ctimes    = 11'(st_reg.pitch * byte_reg);
    assign ltimes    = 18'(st_reg.lp * byte_reg);

    always_comb begin
        st_x   = st_reg;
        n_x    = '0;
        pend_x = P_NONE;
        dvd_x  = '0;
        dvs_x  = '0;
        for (int i = 0; i < 4; i++) ev_x[i] = '0;

        if (!eof_reg && st_reg.phase == PH_IDLE && st_reg.run && printable) begin
            ev_x[n_x[1:0]] = mk_ev(K_GLYPH, st_x.down, st_x.across, {8'h00, byte_reg},
                                   '0, '0);
            n_x = n_x + 3'd1;
            st_x.across = sat_h(17'(st_x.across) + 17'(st_x.pitch));
        end else begin
            // run ends before the byte's own events
            if ((eof_reg || st_x.phase == PH_IDLE) && st_x.run) begin
                st_x.run = 1'b0;
                if ((st_x.font & F_UNDER) != '0) begin
                    ev_x[n_x[1:0]] = mk_ev(K_UNDERLINE, st_x.down, st_x.rstart,
                                           16'(st_x.font & F_ELITE), st_x.across, '0);
                    n_x = n_x + 3'd1;
                    st_x.sfont = 7'(st_x.font & F_ELITE);
                end
                st_x.sacross = ((st_x.font & F_SCRIPT) != '0) ? INV_ACROSS
                                                              : 17'(st_x.across);
            end
            if (eof_reg) begin
                if (st_x.open) begin
                    ev_x[n_x[1:0]] = mk_ev(K_PAGE_END, '0, '0, st_x.pcount, '0, '0);
                    n_x = n_x + 3'd1;
                end
                st_x = st_clear(st_x.pcount);
            end else begin
                case (st_x.phase)
                    PH_ESC: begin
                        st_x.phase = PH_IDLE;
                        st_x.cmd   = byte_reg;
                        unique case (byte_reg) inside
                            CMD_GFX: st_x.phase = PH_GMODE;
                            CMD_GK, CMD_GL, CMD_GY, CMD_GZ: begin
                                st_x.farg  = (byte_reg == CMD_GK) ? 8'd0 :
                                             (byte_reg == CMD_GL) ? 8'd1 :
                                             (byte_reg == CMD_GY) ? 8'd2 : 8'd3;
                                st_x.phase = PH_GLO;
                            end
                            CMD_UNDER, CMD_LSP, CMD_LSP3, CMD_FEED, CMD_SKIPN, CMD_SKIPQ,
                            CMD_SKIPR, CMD_SCRIPT, CMD_LMARG, CMD_FORM, CMD_TABSET,
                            CMD_SKIP:
                                st_x.phase = PH_ARG1;
                            CMD_LS8:  st_x.lp = LINE_EIGHT;
                            CMD_LS7:  st_x.lp = LINE_SEVEN;
                            CMD_LS6:  st_x.lp = LINE_SIX;
                            CMD_ITON: st_x.font = st_x.font | F_ITALIC;
                            CMD_ITOFF: st_x.font = st_x.font & ~F_ITALIC;
                            CMD_BOLDE, CMD_BOLDG: st_x.font = st_x.font | F_BOLD;
                            CMD_BOLDF, CMD_BOLDH: st_x.font = st_x.font & ~F_BOLD;
                            CMD_ELITE: begin
                                st_x.font  = st_x.font | F_ELITE;
                                st_x.pitch = PITCH_ELITE;
                            end
                            CMD_PICA: begin
                                st_x.font  = st_x.font & ~F_ELITE;
                                st_x.pitch = PITCH_PICA;
                            end
                            CMD_NOSCR: st_x.font = st_x.font & ~(F_SCRIPT | F_SUPER);
                            CMD_INIT: begin
                                st_x.open   = 1'b0;
                                st_x.font   = '0;
                                st_x.across = '0;
                                st_x.pitch  = PITCH_PICA;
                                st_x.tab    = TAB_DEFAULT;
                                st_x.lm     = '0;
                                st_x.down   = '0;
                                st_x.lp     = LINE_SIX;
                                st_x.tabd   = '0;
                                st_x.fl     = FORM_DEFAULT;
                            end
                            default: ;
                        endcase
                    end
                    PH_ARG1: begin
                        st_x.phase = PH_IDLE;
                        unique case (st_x.cmd)
                            CMD_UNDER: st_x.font = (byte_reg != '0) ? (st_x.font | F_UNDER)
                                                                    : (st_x.font & ~F_UNDER);
                            CMD_LSP:  st_x.lp = 10'(byte_reg);
                            CMD_LSP3: st_x.lp = 10'(byte_reg) * 10'd3;
                            CMD_FEED: begin
                                st_x.down = sat_v(20'(st_x.down) + 20'(byte_reg));
                                if (st_x.open && st_x.down >= st_x.fl) pend_x = P_PAGE;
                            end
                            CMD_SCRIPT: begin
                                if (byte_reg == '0) st_x.font = st_x.font | F_SUPER;
                                st_x.font = st_x.font | F_SCRIPT;
                            end
                            CMD_LMARG: st_x.lm = ctimes;
                            CMD_FORM: begin
                                if (byte_reg != '0) st_x.fl = ltimes;
                                else st_x.phase = PH_ARG2;
                            end
                            CMD_TABSET, CMD_SKIP: begin
                                st_x.farg  = byte_reg;
                                st_x.phase = PH_ARG2;
                            end
                            default: ;
                        endcase
                    end
                    PH_ARG2: begin
                        st_x.phase = PH_IDLE;
                        unique case (st_x.cmd)
                            CMD_FORM: st_x.fl = 18'(VRES_B * byte_reg);
                            CMD_TABSET: begin
                                if (st_x.farg == '0) st_x.tab = ctimes;
                                else st_x.tabd = ltimes;
                            end
                            CMD_SKIP: begin
                                if (st_x.farg == '0) begin
                                    st_x.across = 16'(ctimes);
                                end else begin
                                    st_x.down = ltimes;
                                    if (st_x.open && st_x.down >= st_x.fl) pend_x = P_PAGE;
                                end
                            end
                            default: ;
                        endcase
                    end
                    PH_GMODE: begin
                        st_x.farg  = byte_reg;
                        st_x.phase = PH_GLO;
                    end
                    PH_GLO: begin
                        st_x.brem  = {8'h00, byte_reg};
                        st_x.phase = PH_GHI;
                    end
                    PH_GHI: begin
                        st_x.brem = {byte_reg, st_x.brem[7:0]};
                        ev_x[n_x[1:0]] = mk_ev(K_GFX_START, st_x.down, st_x.across,
                                               {8'h00, st_x.farg}, '0, st_x.brem);
                        n_x = n_x + 3'd1;
                        st_x.sacross = INV_ACROSS;
                        st_x.sdown   = INV_DOWN;
                        st_x.phase   = (st_x.brem != '0) ? PH_GDATA : PH_IDLE;
                    end
                    PH_GDATA: begin
                        ev_x[n_x[1:0]] = mk_ev(K_GFX_DATA, st_x.down, st_x.across,
                                               {8'h00, byte_reg}, '0, '0);
                        n_x = n_x + 3'd1;
                        st_x.brem = st_x.brem - 16'd1;
                        if (st_x.brem == '0) st_x.phase = PH_IDLE;
                    end
                    default: begin
                        st_x.phase = PH_IDLE;
                        if (byte_reg == C_SPACE && (st_x.font & F_UNDER) == '0) begin
                            st_x.across = sat_h(17'(st_x.across) + 17'(st_x.pitch));
                        end else if (printable) begin
                            if (!st_x.open) begin
                                st_x.pcount = st_x.pcount + 16'd1;
                                ev_x[n_x[1:0]] = mk_ev(K_PAGE_BEGIN, '0, '0, st_x.pcount,
                                                       '0, '0);
                                n_x = n_x + 3'd1;
                                st_x.open    = 1'b1;
                                st_x.sfont   = INV_FONT;
                                st_x.sdown   = INV_DOWN;
                                st_x.sacross = INV_ACROSS;
                            end
                            if (st_x.sdown != {1'b0, st_x.down} ||
                                st_x.sacross != 17'(st_x.across)) begin
                                ev_x[n_x[1:0]] = mk_ev(K_MOVE, st_x.down, st_x.across, '0,
                                                       '0, '0);
                                n_x = n_x + 3'd1;
                                st_x.sdown   = {1'b0, st_x.down};
                                st_x.sacross = 17'(st_x.across);
                            end
                            if (st_x.sfont != {1'b0, st_x.font}) begin
                                ev_x[n_x[1:0]] = mk_ev(K_FONT, '0, '0, 16'(st_x.font), '0,
                                                       '0);
                                n_x = n_x + 3'd1;
                                st_x.sfont = {1'b0, st_x.font};
                            end
                            st_x.rstart = st_x.across;
                            st_x.run    = 1'b1;
                            ev_x[n_x[1:0]] = mk_ev(K_GLYPH, st_x.down, st_x.across,
                                                   {8'h00, byte_reg}, '0, '0);
                            n_x = n_x + 3'd1;
                            st_x.across = sat_h(17'(st_x.across) + 17'(st_x.pitch));
                        end else begin
                            case (byte_reg)
                                C_BS: st_x.across = sat_h(17'(st_x.across)
                                                          - 17'(st_x.pitch));
                                C_HT: begin
                                    if (st_x.tab != '0) begin
                                        if (st_x.across >= $signed({5'b0, st_x.lm}))
                                            pend_x = P_TAB;
                                        else
                                            st_x.across = 16'(st_x.lm);
                                    end
                                end
                                C_LF: begin
                                    st_x.across = 16'(st_x.lm);
                                    st_x.down   = sat_v(20'(st_x.down) + 20'(st_x.lp));
                                    if (st_x.open && st_x.down >= st_x.fl) pend_x = P_PAGE;
                                end
                                C_VT: if (st_x.tabd != '0) pend_x = P_VTAB;
                                C_FF: begin
                                    st_x.down = st_x.fl;
                                    if (st_x.open) begin
                                        st_x.down = '0;
                                        ev_x[n_x[1:0]] = mk_ev(K_PAGE_END, '0, '0,
                                                               st_x.pcount, '0, '0);
                                        n_x = n_x + 3'd1;
                                        st_x.open = 1'b0;
                                    end
                                end
                                C_CR:  st_x.across = 16'(st_x.lm);
                                C_ESC: st_x.phase = PH_ESC;
                                default: ;
                            endcase
                        end
                    end
                endcase
            end
        end

        // a zero form length wraps to 0 without a division
        if (pend_x == P_PAGE && st_x.fl == '0) begin
            st_x.down = '0;
            ev_x[n_x[1:0]] = mk_ev(K_PAGE_END, '0, '0, st_x.pcount, '0, '0);
            n_x = n_x + 3'd1;
            st_x.open = 1'b0;
            pend_x = P_NONE;
        end
        case (pend_x)
            P_PAGE: begin
                dvd_x = st_x.down;
                dvs_x = st_x.fl;
            end
            P_TAB: begin
                dvd_x = 18'(st_x.across - $signed({5'b0, st_x.lm}));
                dvs_x = 18'(st_x.tab);
            end
            P_VTAB: begin
                dvd_x = st_x.down;
                dvs_x = st_x.tabd;
            end
            default: ;
        endcase
    end

    assign tab_sum = 29'(st_reg.lm) + 29'(({1'b0, quo[15:0]} + 17'd1) * st_reg.tab);
    assign vprod   = ({1'b0, quo} + 19'd1) * st_reg.tabd;

    always_comb begin
        st_f = st_reg;
        case (pend_reg)
            P_PAGE: begin
                st_f.down = rem;
                st_f.open = 1'b0;
            end
            P_TAB:  st_f.across = (tab_sum > 29'd32767) ? 16'sh7FFF : 16'(tab_sum);
            P_VTAB: st_f.down = (vprod > 37'(DOWN_MAX)) ? DOWN_MAX : vprod[17:0];
            default: ;
        endcase
    end

    dmei_div #(
        .W(DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.exec && pend_x != P_NONE),
        .dividend (dvd_x),
        .divisor  (dvs_x),
        .done     (div_done),
        .quotient (quo),
        .remainder(rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= st_clear('0);
            evn_reg       <= '0;
            evi_reg       <= '0;
            pend_reg      <= P_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                st_reg   <= st_x;
                evn_reg  <= n_x;
                evi_reg  <= '0;
                pend_reg <= pend_x;
            end
            if (cmd.fin) begin
                st_reg   <= st_f;
                pend_reg <= P_NONE;
                if (pend_reg == P_PAGE) evn_reg <= evn_reg + 3'd1;
            end
            if (cmd.pop) begin
                evi_reg       <= evi_reg + 3'd1;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd.load) begin
            byte_reg <= s_byte;
            eof_reg  <= s_eof;
        end
        if (cmd.exec) begin
            for (int i = 0; i < 4; i++) ev_reg[i] <= ev_x[i];
        end
        if (cmd.fin && pend_reg == P_PAGE) begin
            ev_reg[evn_reg[1:0]] <= mk_ev(K_PAGE_END, '0, '0, st_reg.pcount, '0, '0);
        end
        if (cmd.pop) begin
            out_reg      <= ev_reg[evi_reg[1:0]];
            out_last_reg <= (evi_reg + 3'd1 == evn_reg);
        end
    end

    assign sts.need_div = (pend_reg != P_NONE);
    assign sts.div_done = div_done;
    assign sts.ev_left  = (evi_reg != evn_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_ev     = out_reg;
    assign m_last   = out_last_reg;

endmodule

### sv/dot_matrix_escape_interpreter_core.sv
// Dot-matrix printer command interpreter.
// Slave stream: one request per stream byte. s_tdata[7:0] is the byte;
// s_tlast marks end of job (acts as a form feed, then clears all state
// except the page counter; the data byte is ignored).
// Master stream: zero to four events per request. m_tuser holds the event
// kind, m_tdata the positions, value, underline end and graphics count,
// m_tlast flags the final event of the request.
// Sequence: in the simple case a request passes accept, execute, divide
// check, one pop per event and a closing state. Line
// feed, ESC J and ESC f with a page wrap, horizontal tab and vertical tab
// run the 18-step shared divider before the finish state and the pops.
// s_tready is high only while no request is in work; the last event of a
// request may still sit in the output register when the next is taken.
// If the receiver stalls, events wait in the output register and the
// request stays open; nothing is dropped.
// Reset (aresetn low, synchronous) returns all parser and head state to its
// power-up values, clears the page counter and empties the output.
module dot_matrix_escape_interpreter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    // [17:0] vert_pos, [33:18] horiz_pos, [49:34] event_value,
    // [65:50] underline_end, [81:66] data_count, [87:82] zero
    output logic [87:0] m_tdata,
    output logic [2:0]  m_tuser,   // event_kind
    output logic        m_tlast    // last_of_run
);
    import dmei_pkg::*;

    cmd_t cmd;
    sts_t sts;
    ev_t  ev;

    dmei_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dmei_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_byte  (s_tdata),
        .s_eof   (s_tlast),
        .cmd     (cmd),
        .sts     (sts),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_ev    (ev),
        .m_last  (m_tlast)
    );

    assign m_tuser = ev.kind;
    assign m_tdata = {6'b0, ev.count, ev.uend, ev.value, ev.horiz, ev.vert};

endmodule

### sv/dmei_chk.sv
module dmei_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import dmei_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("event dropped while stalled");

    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_page_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == K_PAGE_BEGIN |-> !m_tlast)
        else $error("page begin ended a request");

endmodule

bind dot_matrix_escape_interpreter_core dmei_chk u_chk (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dmei_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eoj;
    } req_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [17:0]        vert;
        logic signed [15:0] horiz;
        logic [15:0]        value;
        logic signed [15:0] uend;
        logic [15:0]        count;
        logic               last;
    } event_t;

    localparam int WATCH_LIMIT = 4000;

    typedef enum logic [2:0] {
        PS_IDLE, PS_ESC, PS_ARG1, PS_ARG2, PS_GMODE, PS_GLO, PS_GHI, PS_GDATA
    } phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    dot_matrix_escape_interpreter_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // printer state mirror
    phase_t      ph;
    logic [7:0]  cmd_code, arg_first;
    logic [15:0] gfx_left;
    logic [5:0]  font;
    int          across, shown_across, run_from;
    logic [17:0] down;
    logic [18:0] shown_down;
    logic [6:0]  shown_font;
    logic [2:0]  cpitch;
    logic [10:0] htab, lmargin;
    logic [9:0]  lpitch;
    logic [17:0] vtab, form_len;
    logic        page_open, in_run;
    logic [15:0] pages;

    event_t pending_events[$];
    event_t step_events[$];
    req_t   byte_queue[$];

    int  errors = 0;
    bit  quiet_tail = 0;
    bit  hold_send = 0;
    int  accepted = 0;
    int  idle_cycles = 0;
    int  send_gap = 0, recv_gap = 0;

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    function automatic int clip_h(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [17:0] clip_v(longint v);
        return (v > 262143) ? 18'h3FFFF : 18'(v);
    endfunction

    function automatic void add_event(logic [2:0] k, logic [17:0] v, int h,
                                      logic [15:0] val, int ue, logic [15:0] cnt);
        event_t e;
        if (step_events.size() >= 4) return;
        e.kind = k; e.vert = v; e.horiz = 16'(h); e.value = val;
        e.uend = 16'(ue); e.count = cnt; e.last = 1'b0;
        step_events.push_back(e);
    endfunction

    function automatic void clear_printer();
        ph = PS_IDLE; cmd_code = 0; arg_first = 0; gfx_left = 0; font = 0;
        across = 0; down = 0; cpitch = PITCH_PICA; htab = TAB_DEFAULT; lmargin = 0;
        lpitch = LINE_SIX; vtab = 0; form_len = FORM_DEFAULT; page_open = 0;
        shown_font = INV_FONT; shown_down = INV_DOWN; shown_across = 65536;
        in_run = 0; run_from = 0;
    endfunction

    function automatic void page_check();
        if (down < form_len || !page_open) return;
        down = (form_len != 0) ? down % form_len : 18'd0;
        add_event(K_PAGE_END, 0, 0, pages, 0, 0);
        page_open = 0;
    endfunction

    function automatic void close_run();
        if (!in_run) return;
        in_run = 0;
        if ((font & F_UNDER) != 0) begin
            add_event(K_UNDERLINE, down, run_from, 16'(font & F_ELITE), across, 0);
            shown_font = 7'(font & F_ELITE);
        end
        shown_across = ((font & F_SCRIPT) != 0) ? 65536 : across;
    endfunction

    function automatic void put_glyph(logic [7:0] c);
        add_event(K_GLYPH, down, across, 16'(c), 0, 0);
        across = clip_h(across + int'(cpitch));
    endfunction

    function automatic void open_run(logic [7:0] c);
        if (!page_open) begin
            pages = pages + 16'd1;
            add_event(K_PAGE_BEGIN, 0, 0, pages, 0, 0);
            page_open = 1;
            shown_font = INV_FONT; shown_down = INV_DOWN; shown_across = 65536;
        end
        if (shown_down != {1'b0, down} || shown_across != across) begin
            add_event(K_MOVE, down, across, 0, 0, 0);
            shown_down = {1'b0, down}; shown_across = across;
        end
        if (shown_font != {1'b0, font}) begin
            add_event(K_FONT, 0, 0, 16'(font), 0, 0);
            shown_font = {1'b0, font};
        end
        run_from = across;
        in_run = 1;
        put_glyph(c);
    endfunction

    function automatic void idle_byte(logic [7:0] c);
        logic [6:0] lo;
        bit printable;
        int t;
        lo = c[6:0];
        printable = lo >= 7'h20 && lo < 7'h7F;
        if (in_run && printable) begin
            put_glyph(c);
            return;
        end
        close_run();
        if (c == C_SPACE && (font & F_UNDER) == 0) begin
            across = clip_h(across + int'(cpitch));
            return;
        end
        if (printable) begin
            open_run(c);
            return;
        end
        case (c)
            C_BS: across = clip_h(across - int'(cpitch));
            C_HT: if (htab != 0) begin
                t = int'(lmargin);
                if (across >= t) t += ((across - t) / int'(htab) + 1) * int'(htab);
                across = clip_h(t);
            end
            C_LF: begin
                across = int'(lmargin);
                down = clip_v(longint'(down) + lpitch);
                page_check();
            end
            C_VT: if (vtab != 0) down = clip_v((longint'(down) / vtab + 1) * vtab);
            C_FF: begin
                down = form_len;
                page_check();
            end
            C_CR: across = int'(lmargin);
            C_ESC: ph = PS_ESC;
            default: ;
        endcase
    endfunction

    function automatic void escape_letter(logic [7:0] c);
        ph = PS_IDLE;
        cmd_code = c;
        case (c)
            CMD_GFX: ph = PS_GMODE;
            CMD_GK, CMD_GL, CMD_GY, CMD_GZ: begin
                arg_first = (c == CMD_GK) ? 8'd0 : (c == CMD_GL) ? 8'd1 :
                            (c == CMD_GY) ? 8'd2 : 8'd3;
                ph = PS_GLO;
            end
            CMD_UNDER, CMD_LSP, CMD_LSP3, CMD_FEED, CMD_SKIPN, CMD_SKIPQ, CMD_SKIPR,
            CMD_SCRIPT, CMD_LMARG, CMD_FORM, CMD_TABSET, CMD_SKIP: ph = PS_ARG1;
            CMD_LS8: lpitch = LINE_EIGHT;
            CMD_LS7: lpitch = LINE_SEVEN;
            CMD_LS6: lpitch = LINE_SIX;
            CMD_ITON: font |= F_ITALIC;
            CMD_ITOFF: font &= ~F_ITALIC;
            CMD_BOLDE, CMD_BOLDG: font |= F_BOLD;
            CMD_BOLDF, CMD_BOLDH: font &= ~F_BOLD;
            CMD_ELITE: begin font |= F_ELITE; cpitch = PITCH_ELITE; end
            CMD_PICA: begin font &= ~F_ELITE; cpitch = PITCH_PICA; end
            CMD_NOSCR: font &= ~(F_SCRIPT | F_SUPER);
            CMD_INIT: begin
                page_open = 0; font = 0; across = 0; cpitch = PITCH_PICA;
                htab = TAB_DEFAULT; lmargin = 0; down = 0; lpitch = LINE_SIX;
                vtab = 0; form_len = FORM_DEFAULT;
            end
            default: ;
        endcase
    endfunction

    function automatic void first_arg(logic [7:0] c);
        ph = PS_IDLE;
        case (cmd_code)
            CMD_UNDER: if (c != 0) font |= F_UNDER; else font &= ~F_UNDER;
            CMD_LSP: lpitch = 10'(c);
            CMD_LSP3: lpitch = 10'(3 * c);
            CMD_FEED: begin
                down = clip_v(longint'(down) + c);
                page_check();
            end
            CMD_SCRIPT: begin
                if (c == 0) font |= F_SUPER;
                font |= F_SCRIPT;
            end
            CMD_LMARG: lmargin = 11'(cpitch * c);
            CMD_FORM: if (c != 0) form_len = 18'(lpitch * c); else ph = PS_ARG2;
            CMD_TABSET, CMD_SKIP: begin arg_first = c; ph = PS_ARG2; end
            default: ;
        endcase
    endfunction

    function automatic void second_arg(logic [7:0] c);
        ph = PS_IDLE;
        case (cmd_code)
            CMD_FORM: form_len = 18'(VRES * c);
            CMD_TABSET:
                if (arg_first == 0) htab = 11'(cpitch * c);
                else vtab = 18'(lpitch * c);
            CMD_SKIP:
                if (arg_first == 0) across = int'(cpitch) * int'(c);
                else begin
                    down = 18'(lpitch * c);
                    page_check();
                end
            default: ;
        endcase
    endfunction

    // compute events of one accepted request and append them to pending_events
    function automatic void predict_request(req_t r);
        step_events.delete();
        if (r.eoj) begin
            logic [15:0] keep;
            close_run();
            down = form_len;
            page_check();
            keep = pages;
            clear_printer();
            pages = keep;
        end else begin
            case (ph)
                PS_ESC: escape_letter(r.data);
                PS_ARG1: first_arg(r.data);
                PS_ARG2: second_arg(r.data);
                PS_GMODE: begin arg_first = r.data; ph = PS_GLO; end
                PS_GLO: begin gfx_left = 16'(r.data); ph = PS_GHI; end
                PS_GHI: begin
                    gfx_left[15:8] = r.data;
                    add_event(K_GFX_START, down, across, 16'(arg_first), 0, gfx_left);
                    shown_across = 65536; shown_down = INV_DOWN;
                    ph = (gfx_left != 0) ? PS_GDATA : PS_IDLE;
                end
                PS_GDATA: begin
                    add_event(K_GFX_DATA, down, across, 16'(r.data), 0, 0);
                    gfx_left = gfx_left - 16'd1;
                    if (gfx_left == 0) ph = PS_IDLE;
                end
                default: begin
                    ph = PS_IDLE;
                    idle_byte(r.data);
                end
            endcase
        end
        if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i]) pending_events.push_back(step_events[i]);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_request('{data: s_tdata, eoj: s_tlast});
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else if (byte_queue.size() > 0 && !hold_send) begin
                    req_t r;
                    r = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= r.data;
                    s_tlast <= r.eoj;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                event_t exp_ev;
                if (pending_events.size() == 0) begin
                    $error("unexpected event kind %0d", m_tuser);
                    errors++;
                end else begin
                    exp_ev = pending_events.pop_front();
                    if (m_tuser !== exp_ev.kind) begin
                        $error("event_kind exp %0d got %0d", exp_ev.kind, m_tuser); errors++;
                    end
                    if (m_tdata[17:0] !== exp_ev.vert) begin
                        $error("vert_pos exp %0d got %0d", exp_ev.vert, m_tdata[17:0]); errors++;
                    end
                    if (m_tdata[33:18] !== exp_ev.horiz) begin
                        $error("horiz_pos exp %0d got %0d", exp_ev.horiz,
                               $signed(m_tdata[33:18])); errors++;
                    end
                    if (m_tdata[49:34] !== exp_ev.value) begin
                        $error("event_value exp %0d got %0d", exp_ev.value, m_tdata[49:34]);
                        errors++;
                    end
                    if (m_tdata[65:50] !== exp_ev.uend) begin
                        $error("underline_end exp %0d got %0d", exp_ev.uend,
                               $signed(m_tdata[65:50])); errors++;
                    end
                    if (m_tdata[81:66] !== exp_ev.count) begin
                        $error("data_count exp %0d got %0d", exp_ev.count, m_tdata[81:66]);
                        errors++;
                    end
                    if (m_tlast !== exp_ev.last) begin
                        $error("last_of_run exp %0d got %0d", exp_ev.last, m_tlast); errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT) begin
            $display("dot_matrix_escape_interpreter_core: mismatch");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b);
        byte_queue.push_back('{data: b, eoj: 1'b0});
    endtask

    task automatic push_esc(logic [7:0] letter, logic [7:0] a);
        push_byte(C_ESC); push_byte(letter); push_byte(a);
    endtask

    task automatic push_text(int n);
        repeat (n)
            push_byte(8'($urandom_range(8'h20, 8'h7E)) |
                      (($urandom_range(0, 7) == 0) ? 8'h80 : 8'h00));
    endtask

    task automatic push_random_sequence();
        int pick;
        logic [7:0] letters[] = '{CMD_UNDER, CMD_LSP, CMD_LSP3, CMD_FEED, CMD_SKIPN,
            CMD_SKIPQ, CMD_SKIPR, CMD_SCRIPT, CMD_LMARG, CMD_FORM, CMD_TABSET, CMD_SKIP,
            CMD_LS8, CMD_LS7, CMD_LS6, CMD_ITON, CMD_ITOFF, CMD_BOLDE, CMD_BOLDG,
            CMD_BOLDF, CMD_BOLDH, CMD_ELITE, CMD_PICA, CMD_NOSCR, CMD_INIT};
        logic [7:0] ctrls[] = '{C_BS, C_HT, C_LF, C_VT, C_FF, C_CR, C_SPACE};
        pick = $urandom_range(0, 99);
        if (pick < 35) push_text($urandom_range(1, 6));
        else if (pick < 55) push_byte(ctrls[$urandom_range(0, ctrls.size() - 1)]);
        else if (pick < 80) begin
            push_byte(C_ESC);
            push_byte(letters[$urandom_range(0, letters.size() - 1)]);
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
            int n;
            n = $urandom_range(0, 4);
            push_byte(C_ESC);
            if ($urandom_range(0, 1)) begin
                push_byte(CMD_GFX); push_byte(8'($urandom));
            end else push_byte(CMD_GK + 8'($urandom_range(0, 1)));
            push_byte(8'(n)); push_byte(8'h00);
            repeat (n) push_byte(8'($urandom));
        end else if (pick < 97) push_byte(8'($urandom));
        else byte_queue.push_back('{data: 8'($urandom), eoj: 1'b1});
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b0;
        clear_printer();
        pages = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: text, underline run, elite, scripts, tabs, feeds, graphics
        push_byte(8'h41); push_byte(8'hFF); push_byte(C_SPACE); push_byte(8'h7E);
        push_esc(CMD_UNDER, 8'd1); push_byte(C_SPACE); push_byte(8'hA0); push_byte(C_CR);
        push_byte(C_ESC); push_byte(CMD_ELITE); push_esc(CMD_SCRIPT, 8'd0);
        push_text(2); push_byte(C_HT); push_byte(C_VT); push_esc(CMD_TABSET, 8'd1);
        push_byte(8'd5); push_byte(C_VT); push_esc(CMD_TABSET, 8'd0); push_byte(8'd0);
        push_byte(C_HT); push_esc(CMD_FORM, 8'd0); push_byte(8'd0); push_byte(C_LF);
        push_byte(C_ESC); push_byte(CMD_GZ); push_byte(8'd2); push_byte(8'd0);
        push_byte(8'h00); push_byte(8'hFF); push_text(1);
        push_esc(CMD_SKIP, 8'd0); push_byte(8'd255); push_esc(CMD_SKIP, 8'd1);
        push_byte(8'd255); push_esc(CMD_FEED, 8'd255); push_byte(C_BS); push_byte(C_FF);
        push_byte(C_ESC); push_byte(CMD_GFX); push_byte(8'd5); push_byte(8'hFF);
        push_byte(8'hFF); push_byte(8'h55); push_byte(8'hAA);
        byte_queue.push_back('{data: 8'h00, eoj: 1'b1});
        push_byte(C_ESC); push_byte(8'h7A); push_byte(C_ESC); push_byte(CMD_INIT);
        push_text(1);
        byte_queue.push_back('{data: 8'hFF, eoj: 1'b1});
        wait (byte_queue.size() == 0 && pending_events.size() == 0);

        // sender holds off until every expected event has come
        hold_send = 1;
        push_text(3);
        @(posedge aclk);
        wait (!s_tvalid && pending_events.size() == 0);
        repeat (30) @(posedge aclk);
        hold_send = 0;

        while (accepted < 470) begin
            if (byte_queue.size() < 8) push_random_sequence();
            if (accepted > 400) quiet_tail = 1;
            @(posedge aclk);
        end
        wait (byte_queue.size() == 0);
        wait (pending_events.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0 && pending_events.size() == 0)
            $display("dot_matrix_escape_interpreter_core: match");
        else
            $display("dot_matrix_escape_interpreter_core: mismatch");
        $finish;
    end
endmodule
